FILE: rtl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types and constants for the LSB-first bit packer: item structs,
// request codes and the command control word passed from front to back.
// ----------------------------------------------------------------------------
package lbp_pkg;

  localparam int unsigned LBP_MAX_BITS    = 32;
  localparam int unsigned LBP_VALUE_W     = 32;
  localparam int unsigned LBP_BITCNT_W    = 6;
  localparam int unsigned LBP_CNT_W       = 24;
  // byte count of one command; covers up to 15 bytes per item
  localparam int unsigned LBP_EMIT_W      = 4;
  localparam int unsigned LBP_Q_DEPTH     = 2;

  localparam logic [LBP_CNT_W-1:0] LBP_CAP_RESET = '1;

  localparam logic LBP_REQ_WRITE = 1'b0;
  localparam logic LBP_REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic [LBP_VALUE_W-1:0]  value;
    logic [LBP_BITCNT_W-1:0] bit_count;
  } lbp_in_t;

  typedef struct packed {
    logic [7:0]           out_byte;
    logic                 byte_valid;
    logic                 ok;
    logic                 last;
    logic [LBP_CNT_W-1:0] bytes_written;
  } lbp_out_t;

  typedef struct packed {
    logic                  fail;
    logic [LBP_EMIT_W-1:0] emit;
    logic [LBP_CNT_W-1:0]  base;
  } lbp_ctl_t;

endpackage

FILE: rtl/lbp_front.sv
// ----------------------------------------------------------------------------
// lbp_front
// Accepts items, merges new bits with the partial byte, checks capacity and
// issues one command per item that says how many bytes to deliver.
// ----------------------------------------------------------------------------
module lbp_front #(
  parameter int unsigned MAX_BITS = lbp_pkg::LBP_MAX_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [lbp_pkg::LBP_CNT_W-1:0]         cfg_wdata_i,
  input  logic                                  accept_i,
  input  lbp_pkg::lbp_in_t                      in_item_i,
  output lbp_pkg::lbp_ctl_t                     cmd_ctl_o,
  output logic [((MAX_BITS+7)/8)*8-1:0]         cmd_word_o
);

  localparam int unsigned NumBytes = (MAX_BITS + 7) / 8;
  localparam int unsigned WordW    = (NumBytes + 1) * 8;
  localparam int unsigned CntW     = $clog2(MAX_BITS + 1);
  localparam int unsigned SumW     = CntW + 1;
  localparam int unsigned EmitW    = lbp_pkg::LBP_EMIT_W;
  localparam int unsigned CountW   = lbp_pkg::LBP_CNT_W;

  logic [CountW-1:0] cap_q;
  logic [6:0]        partial_q, partial_d;
  logic [2:0]        pos_q, pos_d;
  logic [CountW-1:0] count_q, count_d;

  logic [CntW-1:0]   cnt_cap;
  logic [WordW-1:0]  val_ext, in_bits, word;
  logic [SumW-1:0]   sum;
  logic [EmitW-1:0]  nbytes;
  logic [6:0]        rem;
  logic [CountW-1:0] avail;
  logic              at_cap;

  always_comb begin
    if (32'(in_item_i.bit_count) > 32'(MAX_BITS)) begin
      cnt_cap = CntW'(MAX_BITS);
    end else begin
      cnt_cap = CntW'(in_item_i.bit_count);
    end

    val_ext = WordW'(in_item_i.value);
    for (int i = 0; i < WordW; i++) begin
      in_bits[i] = val_ext[i] & (i < int'(cnt_cap));
    end

    word   = (in_bits << pos_q) | WordW'(partial_q);
    sum    = SumW'(pos_q) + SumW'(cnt_cap);
    nbytes = EmitW'(sum >> 3);

    rem = '0;
    for (int j = 0; j <= NumBytes; j++) begin
      if (nbytes == EmitW'(j)) begin
        rem = word[j*8 +: 7];
      end
    end

    avail  = cap_q - count_q;
    at_cap = (count_q >= cap_q);

    cmd_ctl_o.fail = 1'b0;
    cmd_ctl_o.emit = '0;
    cmd_ctl_o.base = count_q;
    cmd_word_o     = word[NumBytes*8-1:0];
    partial_d      = partial_q;
    pos_d          = pos_q;

    if (at_cap) begin
      cmd_ctl_o.fail = 1'b1;
    end else if (in_item_i.req_type == lbp_pkg::LBP_REQ_FLUSH) begin
      cmd_word_o = (NumBytes*8)'(partial_q);
      if (pos_q != 3'd0) begin
        cmd_ctl_o.emit = EmitW'(1);
      end
      partial_d = '0;
      pos_d     = '0;
    end else if (avail >= CountW'(nbytes)) begin
      cmd_ctl_o.emit = nbytes;
      partial_d      = rem;
      pos_d          = sum[2:0];
    end else begin
      // capacity runs out inside this write: drop the rest
      cmd_ctl_o.emit = avail[EmitW-1:0];
      cmd_ctl_o.fail = 1'b1;
      partial_d      = '0;
      pos_d          = '0;
    end

    count_d = count_q + CountW'(cmd_ctl_o.emit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= lbp_pkg::LBP_CAP_RESET;
      partial_q <= '0;
      pos_q     <= '0;
      count_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        partial_q <= partial_d;
        pos_q     <= pos_d;
        count_q   <= count_d;
      end
    end
  end

  // bits above the current position are always clear
  a_partial_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (partial_q >> pos_q) == 7'd0)
    else $error("partial byte holds bits above bit position");

endmodule

FILE: rtl/lbp_cmd_fifo.sv
// ----------------------------------------------------------------------------
// lbp_cmd_fifo
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module lbp_cmd_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = lbp_pkg::LBP_Q_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             not_empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;

  assign full_o      = (count_q == CntW'(Depth));
  assign not_empty_o = (count_q != '0);
  assign rd_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (rd_en_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      case ({wr_en_i, rd_en_i})
        2'b10:   count_q <= count_q + CntW'(1);
        2'b01:   count_q <= count_q - CntW'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: rtl/lbp_back.sv
// ----------------------------------------------------------------------------
// lbp_back
// Walks each command one result per cycle, while the reader pops, into a registered output stage.
// ----------------------------------------------------------------------------
module lbp_back #(
  parameter int unsigned MAX_BITS = lbp_pkg::LBP_MAX_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_vld_i,
  input  lbp_pkg::lbp_ctl_t             head_ctl_i,
  input  logic [((MAX_BITS+7)/8)*8-1:0] head_word_i,
  output logic                          head_pop_o,
  input  logic                          pop,
  output logic                          empty,
  output lbp_pkg::lbp_out_t             out_item_o
);

  localparam int unsigned NumBytes = (MAX_BITS + 7) / 8;
  localparam int unsigned EmitW    = lbp_pkg::LBP_EMIT_W;
  localparam int unsigned CountW   = lbp_pkg::LBP_CNT_W;

  logic [EmitW-1:0]  idx_q;
  logic              out_vld_q;
  lbp_pkg::lbp_out_t out_q, res;
  logic              is_byte, advance;
  logic [7:0]        sel_byte;

  always_comb begin
    sel_byte = '0;
    for (int j = 0; j < NumBytes; j++) begin
      if (idx_q == EmitW'(j)) begin
        sel_byte = head_word_i[j*8 +: 8];
      end
    end

    is_byte = (idx_q < head_ctl_i.emit);

    res.out_byte      = is_byte ? sel_byte : 8'd0;
    res.byte_valid    = is_byte;
    res.ok            = is_byte | ~head_ctl_i.fail;
    res.last          = is_byte ? ((idx_q == head_ctl_i.emit - EmitW'(1)) & ~head_ctl_i.fail)
                                : 1'b1;
    res.bytes_written = head_ctl_i.base + CountW'(idx_q) + CountW'(is_byte);
  end

  assign advance    = !out_vld_q || pop;
  assign head_pop_o = advance && head_vld_i && res.last;
  assign empty      = !out_vld_q;
  assign out_item_o = out_q;

  always_ff @(posedge clk_i) begin
    if (advance && head_vld_i) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= head_vld_i;
      if (head_vld_i) begin
        // advance within the command, or restart on its final result
        idx_q <= res.last ? '0 : idx_q + EmitW'(1);
      end
    end
  end

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_vld_i |-> idx_q <= head_ctl_i.emit)
    else $error("result index ran past the command byte count");

  a_novalid_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.byte_valid) |-> (out_q.last && out_q.out_byte == 8'd0))
    else $error("byteless result must close its transaction with a zero byte");

  a_fail_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.ok) |-> (out_q.last && !out_q.byte_valid))
    else $error("failure reported on a result that is not final");

endmodule

FILE: rtl/lsb_first_bit_packer_unit.sv
// ----------------------------------------------------------------------------
// lsb_first_bit_packer_unit
// Packs bit fields into bytes, least significant bit first, with a byte
// capacity limit and zero-padded flush.
//
//   channel  direction  handshake          payload
//   input    in         push / full        in_item_i  (lbp_in_t)
//   result   out        pop / empty        out_item_o (lbp_out_t)
//   config   in         cfg_we_i           cfg_wdata_i (capacity in bytes)
//
// An item gives 1 to 4 results at MAX_BITS = 32, which the output stage
// delivers one per cycle while the reader pops.
// A result passes through the command queue and the output register before it shows on the outputs.
// Reset sets capacity to 16777215 and clears the partial byte and count;
// there is no clearing pass.
// Input and result sides stall independently through the command queue and
// the output register.
// ----------------------------------------------------------------------------
module lsb_first_bit_packer_unit #(
  parameter int unsigned MAX_BITS = lbp_pkg::LBP_MAX_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lbp_pkg::LBP_CNT_W-1:0] cfg_wdata_i,
  input  logic                          push,
  output logic                          full,
  input  lbp_pkg::lbp_in_t              in_item_i,
  input  logic                          pop,
  output logic                          empty,
  output lbp_pkg::lbp_out_t             out_item_o
);

  localparam int unsigned NumBytes = (MAX_BITS + 7) / 8;
  localparam int unsigned WordW    = NumBytes * 8;
  localparam int unsigned QueueW   = $bits(lbp_pkg::lbp_ctl_t) + WordW;

  logic              accept;
  lbp_pkg::lbp_ctl_t cmd_ctl, head_ctl;
  logic [WordW-1:0]  cmd_word, head_word;
  logic              head_vld, head_pop;

  assign accept = push && !full;

  lbp_front #(
    .MAX_BITS (MAX_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_item_i   (in_item_i),
    .cmd_ctl_o   (cmd_ctl),
    .cmd_word_o  (cmd_word)
  );

  lbp_cmd_fifo #(
    .Width (QueueW),
    .Depth (lbp_pkg::LBP_Q_DEPTH)
  ) u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (accept),
    .wr_data_i   ({cmd_ctl, cmd_word}),
    .full_o      (full),
    .rd_en_i     (head_pop),
    .rd_data_o   ({head_ctl, head_word}),
    .not_empty_o (head_vld)
  );

  lbp_back #(
    .MAX_BITS (MAX_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_vld_i  (head_vld),
    .head_ctl_i  (head_ctl),
    .head_word_i (head_word),
    .head_pop_o  (head_pop),
    .pop         (pop),
    .empty       (empty),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: test/tb_lsb_first_bit_packer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lsb_first_bit_packer_unit
// Self-checking bench for the LSB-first bit packer. A scoreboard predicts
// every emitted byte, the ok and last flags and the running byte count from
// each accepted item, and compares the results in order. A directed part
// covers the field extremes and the capacity corner cases. It is followed
// by random phases under several capacity settings, with bursty pushes and
// a stalling reader.
// ----------------------------------------------------------------------------
module tb_lsb_first_bit_packer_unit;

  localparam int unsigned CLK_PERIOD  = 12;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE      = 6;
  localparam int unsigned CNT_W       = lbp_pkg::LBP_CNT_W;

  class packer_scoreboard;
    logic [CNT_W-1:0]  capacity;
    logic [6:0]        partial;
    logic [2:0]        fill;
    logic [CNT_W-1:0]  byte_count;
    lbp_pkg::lbp_out_t expected_bytes[$];
    int                errors;
    int                items_seen;
    int                flushes_seen;
    int                refusals;
    int                results_checked;

    function new();
      capacity        = lbp_pkg::LBP_CAP_RESET;
      partial         = '0;
      fill            = '0;
      byte_count      = '0;
      errors          = 0;
      items_seen      = 0;
      flushes_seen    = 0;
      refusals        = 0;
      results_checked = 0;
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
      errors++;
    endtask

    function lbp_pkg::lbp_out_t make_result(logic [7:0] b, logic v, logic okv,
                                            logic lastv);
      lbp_pkg::lbp_out_t r;
      r.out_byte      = b;
      r.byte_valid    = v;
      r.ok            = okv;
      r.last          = lastv;
      r.bytes_written = byte_count;
      return r;
    endfunction

    // Predict all results of one accepted item and queue them.
    function void note_item(lbp_pkg::lbp_in_t it);
      int unsigned       n_bits;
      logic [7:0]        acc;
      logic [3:0]        pos;
      lbp_pkg::lbp_out_t held;
      bit                have_held;
      int unsigned       i;

      items_seen++;
      if (it.req_type == lbp_pkg::LBP_REQ_FLUSH) flushes_seen++;
      have_held = 1'b0;
      if (byte_count >= capacity) begin
        refusals++;
        expected_bytes.push_back(make_result(8'h00, 1'b0, 1'b0, 1'b1));
        return;
      end
      if (it.req_type == lbp_pkg::LBP_REQ_FLUSH) begin
        if (fill != 0) begin
          byte_count = byte_count + 1'b1;
          expected_bytes.push_back(make_result({1'b0, partial}, 1'b1, 1'b1, 1'b1));
          partial = '0;
          fill    = '0;
        end else begin
          expected_bytes.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b1));
        end
        return;
      end
      n_bits = (it.bit_count > lbp_pkg::LBP_MAX_BITS) ? lbp_pkg::LBP_MAX_BITS
                                                      : it.bit_count;
      acc = {1'b0, partial};
      pos = {1'b0, fill};
      for (i = 0; i < n_bits; i++) begin
        acc[pos[2:0]] = (i < lbp_pkg::LBP_VALUE_W) ? it.value[i] : 1'b0;
        pos++;
        if (pos == 4'd8) begin
          if (byte_count >= capacity) begin
            // drop the full byte and every bit still to come
            partial = '0;
            fill    = '0;
            refusals++;
            if (have_held) expected_bytes.push_back(held);
            expected_bytes.push_back(make_result(8'h00, 1'b0, 1'b0, 1'b1));
            return;
          end
          byte_count = byte_count + 1'b1;
          if (have_held) expected_bytes.push_back(held);
          held      = make_result(acc, 1'b1, 1'b1, 1'b0);
          have_held = 1'b1;
          acc = '0;
          pos = '0;
        end
      end
      partial = acc[6:0];
      fill    = pos[2:0];
      if (have_held) begin
        held.last = 1'b1;
        expected_bytes.push_back(held);
      end else begin
        expected_bytes.push_back(make_result(8'h00, 1'b0, 1'b1, 1'b1));
      end
    endfunction

    task check_byte(lbp_pkg::lbp_out_t got);
      lbp_pkg::lbp_out_t want;
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected result, out_byte", {24'h0, got.out_byte}, 32'h0);
        return;
      end
      want = expected_bytes.pop_front();
      results_checked++;
      if (got.out_byte !== want.out_byte)
        report_mismatch("out_byte", {24'h0, got.out_byte}, {24'h0, want.out_byte});
      if (got.byte_valid !== want.byte_valid)
        report_mismatch("byte_valid", {31'h0, got.byte_valid}, {31'h0, want.byte_valid});
      if (got.ok !== want.ok)
        report_mismatch("ok", {31'h0, got.ok}, {31'h0, want.ok});
      if (got.last !== want.last)
        report_mismatch("last", {31'h0, got.last}, {31'h0, want.last});
      if (got.bytes_written !== want.bytes_written)
        report_mismatch("bytes_written", {8'h0, got.bytes_written},
                        {8'h0, want.bytes_written});
    endtask

    function int pending();
      return expected_bytes.size();
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CNT_W-1:0]  cfg_wdata_i;
  logic              push;
  logic              full;
  lbp_pkg::lbp_in_t  in_item_i;
  logic              pop = 1'b0;
  logic              empty;
  lbp_pkg::lbp_out_t out_item_o;

  packer_scoreboard sb = new();
  int unsigned      cycles;
  int               cap_writes;

  logic [1:0] pop_mode = 2'd0;
  logic [5:0] pop_phase = '0;
  logic [2:0] stall_left = '0;

  lsb_first_bit_packer_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .pop        (pop),
    .empty      (empty),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Note each accepted transaction on both channels.
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) sb.note_item(in_item_i);
    if (rst_ni && pop && !empty) sb.check_byte(out_item_o);
  end

  // Reader: the mode is redrawn each time the phase counter wraps; steady, random, or bursts of stalls.
  always @(negedge clk_i) begin
    pop_phase <= pop_phase + 1'b1;
    if (pop_phase == '1) pop_mode <= 2'($urandom_range(0, 2));
    if (stall_left != 0) begin
      pop        <= 1'b0;
      stall_left <= stall_left - 1'b1;
    end else begin
      case (pop_mode)
        2'd0: pop <= 1'b1;
        2'd1: pop <= 1'($urandom_range(0, 1));
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            pop        <= 1'b0;
            stall_left <= 3'($urandom_range(1, 6));
          end else begin
            pop <= 1'b1;
          end
        end
      endcase
    end
  end

  task send_item(input logic req, input logic [31:0] v, input logic [5:0] cnt);
    lbp_pkg::lbp_in_t it;
    it.req_type  = req;
    it.value     = v;
    it.bit_count = cnt;
    @(negedge clk_i);
    push      <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
  endtask

  task end_burst();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  // Hold until every predicted result has been popped, then let the block settle.
  task wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task set_capacity(input logic [CNT_W-1:0] cap);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.capacity = cap;
    cap_writes++;
  endtask

  task send_random_item();
    logic       req;
    logic [5:0] cnt;
    int unsigned pick;
    req  = ($urandom_range(0, 4) == 0) ? lbp_pkg::LBP_REQ_FLUSH : lbp_pkg::LBP_REQ_WRITE;
    pick = $urandom_range(0, 9);
    if (pick <= 6)      cnt = 6'($urandom_range(1, 32));
    else if (pick == 7) cnt = ($urandom_range(0, 1) != 0) ? 6'd32 : 6'd0;
    else if (pick == 8) cnt = 6'($urandom_range(33, 63));
    else                cnt = 6'($urandom_range(0, 63));
    send_item(req, $urandom, cnt);
  endtask

  task run_random_phase(input int n_items, input bit pause_midway);
    int sent;
    int burst;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 12);
      while (burst > 0 && sent < n_items) begin
        send_random_item();
        sent++;
        burst--;
        if (pause_midway && sent == n_items / 2) begin
          end_burst();
          wait_drained();
        end
      end
      // Zero gap keeps push high into the next burst.
      if ($urandom_range(0, 3) != 0) begin
        end_burst();
        repeat ($urandom_range(0, 5)) @(negedge clk_i);
      end
    end
    end_burst();
  endtask

  initial begin
    logic [CNT_W-1:0] cap;

    cycles      = 0;
    cap_writes  = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    push        = 1'b0;
    in_item_i   = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, flush cases and unaligned packing.
    set_capacity(lbp_pkg::LBP_CAP_RESET);
    send_item(lbp_pkg::LBP_REQ_WRITE, 32'hFFFF_FFFF, 6'd0);
    send_item(lbp_pkg::LBP_REQ_FLUSH, 32'h0, 6'd0);
    send_item(lbp_pkg::LBP_REQ_WRITE, 32'h0000_0001, 6'd1);
    send_item(lbp_pkg::LBP_REQ_FLUSH, 32'hFFFF_FFFF, 6'd63);
    send_item(lbp_pkg::LBP_REQ_WRITE, 32'hFFFF_FFFF, 6'd32);
    send_item(lbp_pkg::LBP_REQ_WRITE, 32'h0000_0000, 6'd32);
    send_item(lbp_pkg::LBP_REQ_WRITE, 32'hDEAD_BEEF, 6'd63);
    send_item(lbp_pkg::LBP_REQ_WRITE, 32'hFFFF_FF7F, 6'd7);
    send_item(lbp_pkg::LBP_REQ_WRITE, 32'h8000_0001, 6'd32);
    send_item(lbp_pkg::LBP_REQ_FLUSH, 32'h0, 6'd0);
    send_item(lbp_pkg::LBP_REQ_WRITE, 32'hFFFF_FFA5, 6'd8);
    send_item(lbp_pkg::LBP_REQ_WRITE, 32'hC3C3_C3C3, 6'd33);
    send_item(lbp_pkg::LBP_REQ_WRITE, 32'hFFFF_FFFE, 6'd3);
    end_burst();
    wait_drained();

    // Capacity reached inside a write, then write and flush at capacity.
    set_capacity(CNT_W'(sb.byte_count + 3));
    send_item(lbp_pkg::LBP_REQ_WRITE, 32'h0000_0015, 6'd5);
    send_item(lbp_pkg::LBP_REQ_WRITE, 32'h1234_5678, 6'd32);
    send_item(lbp_pkg::LBP_REQ_WRITE, 32'hFFFF_FFFF, 6'd8);
    send_item(lbp_pkg::LBP_REQ_FLUSH, 32'h0, 6'd0);
    end_burst();
    wait_drained();

    // Zero capacity refuses everything.
    set_capacity('0);
    send_item(lbp_pkg::LBP_REQ_WRITE, 32'h0000_00FF, 6'd8);
    send_item(lbp_pkg::LBP_REQ_FLUSH, 32'h0, 6'd0);
    end_burst();
    wait_drained();

    // Capacity lowered below the running count.
    set_capacity(sb.byte_count - 1'b1);
    send_item(lbp_pkg::LBP_REQ_WRITE, 32'hAAAA_AAAA, 6'd16);
    send_item(lbp_pkg::LBP_REQ_FLUSH, 32'h0, 6'd0);
    end_burst();
    wait_drained();

    // Random phases.
    set_capacity(lbp_pkg::LBP_CAP_RESET);
    run_random_phase(70, 1'b1);
    wait_drained();
    set_capacity(CNT_W'(sb.byte_count + 40));
    run_random_phase(60, 1'b0);
    wait_drained();
    set_capacity(lbp_pkg::LBP_CAP_RESET);
    run_random_phase(70, 1'b0);
    wait_drained();
    cap = sb.byte_count >> 1;
    set_capacity(cap);
    run_random_phase(20, 1'b0);
    wait_drained();
    set_capacity(CNT_W'(sb.byte_count + 100));
    run_random_phase(70, 1'b0);
    wait_drained();
    set_capacity(CNT_W'($urandom_range(0, 24'hFF_FFFF)));
    run_random_phase(70, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report_mismatch("results never delivered", sb.pending(), 32'h0);

    $display("Summary: %0d items accepted (%0d flushes), %0d results checked",
             sb.items_seen, sb.flushes_seen, sb.results_checked);
    $display("Summary: %0d capacity refusals across %0d capacity settings, %0d bytes",
             sb.refusals, cap_writes, sb.byte_count);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
